>>> design/ebt_pkg.sv
`default_nettype none
package ebt_pkg;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7a;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5a;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_EQUALS = 8'h3d;

	localparam logic [3:0] KIND_PLUS   = 4'd0;
	localparam logic [3:0] KIND_MINUS  = 4'd1;
	localparam logic [3:0] KIND_STAR   = 4'd2;
	localparam logic [3:0] KIND_SLASH  = 4'd3;
	localparam logic [3:0] KIND_LPAREN = 4'd4;
	localparam logic [3:0] KIND_RPAREN = 4'd5;
	localparam logic [3:0] KIND_SEMI   = 4'd6;
	localparam logic [3:0] KIND_EQUALS = 4'd7;
	localparam logic [3:0] KIND_SPACE  = 4'd8;
	localparam logic [3:0] KIND_NUMBER = 4'd9;
	localparam logic [3:0] KIND_IDENT  = 4'd10;
	localparam logic [3:0] KIND_END    = 4'd11;

	localparam logic [15:0] START_CAP = 16'hffff;

	// power of two so the queue pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;
	localparam int SLOTS = 3;

	typedef enum logic [1:0] {
		RUN_NONE   = 2'd0,
		RUN_SPACE  = 2'd1,
		RUN_NUMBER = 2'd2,
		RUN_IDENT  = 2'd3
	} run_cls_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [16:0] len;
	} tok_t;

	// all tokens caused by one source item, in emission order
	typedef struct packed {
		logic [SLOTS-1:0] vld;
		tok_t [SLOTS-1:0] tok;
	} bundle_t;

	function automatic logic [3:0] run_kind(input run_cls_t cls);
		logic [3:0] k;
		case (cls)
			RUN_SPACE:  k = KIND_SPACE;
			RUN_NUMBER: k = KIND_NUMBER;
			RUN_IDENT:  k = KIND_IDENT;
			default:    k = KIND_END;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

>>> design/ebt_front.sv
`default_nettype none
module ebt_front #(
	parameter int MAX_SOURCE_BYTES = 65536
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             src_valid,
	output logic                  src_ready,
	input  wire logic [7:0]       source_byte,
	input  wire logic             byte_present,
	input  wire logic             end_of_source,
	input  wire logic             q_full,
	output logic                  q_push,
	output ebt_pkg::bundle_t      q_wdata
);
	import ebt_pkg::*;

	localparam logic [16:0] CAP = (MAX_SOURCE_BYTES > 131071) ? 17'h1ffff :
		17'(MAX_SOURCE_BYTES);

	run_cls_t    cls_q;
	logic [15:0] start_q;
	logic [16:0] len_q;
	logic [16:0] pos_q;

	run_cls_t    cls_a, cls_c;
	logic [15:0] start_a;
	logic [16:0] len_a;
	logic [16:0] pos_a;
	logic [15:0] pos_clip, end_clip;
	logic        is_op, accept;
	logic [3:0]  op_kind;
	bundle_t     b;

	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;

	always_comb begin
		is_op   = 1'b1;
		op_kind = KIND_PLUS;
		case (source_byte)
			CH_PLUS:   op_kind = KIND_PLUS;
			CH_MINUS:  op_kind = KIND_MINUS;
			CH_STAR:   op_kind = KIND_STAR;
			CH_SLASH:  op_kind = KIND_SLASH;
			CH_LPAREN: op_kind = KIND_LPAREN;
			CH_RPAREN: op_kind = KIND_RPAREN;
			CH_SEMI:   op_kind = KIND_SEMI;
			CH_EQUALS: op_kind = KIND_EQUALS;
			default:   is_op = 1'b0;
		endcase
	end

	always_comb begin
		if (source_byte == CH_SPACE || source_byte == CH_TAB || source_byte == CH_NL) begin
			cls_c = RUN_SPACE;
		end else if (source_byte >= CH_ZERO && source_byte <= CH_NINE) begin
			// digits extend an identifier
			cls_c = (cls_q == RUN_IDENT) ? RUN_IDENT : RUN_NUMBER;
		end else if ((source_byte >= CH_LOW_A && source_byte <= CH_LOW_Z) ||
				(source_byte >= CH_UP_A && source_byte <= CH_UP_Z) ||
				source_byte == CH_UNDER) begin
			cls_c = RUN_IDENT;
		end else begin
			cls_c = RUN_NONE;
		end
	end

	always_comb begin
		pos_clip = (pos_q > {1'b0, START_CAP}) ? START_CAP : pos_q[15:0];
		b        = '0;
		cls_a    = cls_q;
		start_a  = start_q;
		len_a    = len_q;
		pos_a    = pos_q;

		if (byte_present) begin
			if (is_op || cls_c == RUN_NONE || cls_c != cls_q) begin
				// any open run ends here
				b.vld[0]       = (cls_q != RUN_NONE);
				b.tok[0].kind  = run_kind(cls_q);
				b.tok[0].start = start_q;
				b.tok[0].len   = len_q;
				if (is_op || cls_c == RUN_NONE) begin
					cls_a   = RUN_NONE;
					start_a = '0;
					len_a   = '0;
				end else begin
					cls_a   = cls_c;
					start_a = pos_clip;
					len_a   = 17'd1;
				end
			end else if (len_q < CAP) begin
				len_a = len_q + 17'd1;
			end
			if (pos_q < CAP) begin
				pos_a = pos_q + 17'd1;
			end
		end

		end_clip = (pos_a > {1'b0, START_CAP}) ? START_CAP : pos_a[15:0];

		if (byte_present && is_op) begin
			b.vld[1]       = 1'b1;
			b.tok[1].kind  = op_kind;
			b.tok[1].start = pos_clip;
			b.tok[1].len   = 17'd1;
		end else if (end_of_source) begin
			b.vld[1]       = (cls_a != RUN_NONE);
			b.tok[1].kind  = run_kind(cls_a);
			b.tok[1].start = start_a;
			b.tok[1].len   = len_a;
		end

		if (end_of_source) begin
			b.vld[2]       = 1'b1;
			b.tok[2].kind  = KIND_END;
			b.tok[2].start = end_clip;
			b.tok[2].len   = '0;
		end
	end

	assign q_push  = accept && (b.vld != '0);
	assign q_wdata = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q   <= RUN_NONE;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			if (end_of_source) begin
				cls_q   <= RUN_NONE;
				start_q <= '0;
				len_q   <= '0;
				pos_q   <= '0;
			end else begin
				cls_q   <= cls_a;
				start_q <= start_a;
				len_q   <= len_a;
				pos_q   <= pos_a;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/ebt_queue.sv
`default_nettype none
module ebt_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ebt_pkg::bundle_t  wdata,
	input  wire logic              pop,
	output ebt_pkg::bundle_t       rdata,
	output logic                   full,
	output logic                   empty
);
	import ebt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	bundle_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

>>> design/ebt_back.sv
`default_nettype none
module ebt_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ebt_pkg::bundle_t  q_rdata,
	input  wire logic              q_empty,
	output logic                   q_pop,
	output logic                   tok_valid,
	input  wire logic              tok_ready,
	output logic [3:0]             token_kind,
	output logic [15:0]            token_start,
	output logic [16:0]            token_length,
	output logic                   final_token
);
	import ebt_pkg::*;

	logic [SLOTS-1:0] vld_q;
	tok_t [SLOTS-1:0] tok_q;
	logic [SLOTS-1:0] sel_oh, rest;
	tok_t             cur;
	logic             xfer, load_ok;

	always_comb begin
		sel_oh = '0;
		cur    = tok_q[SLOTS-1];
		if (vld_q[0]) begin
			sel_oh[0] = 1'b1;
			cur       = tok_q[0];
		end else if (vld_q[1]) begin
			sel_oh[1] = 1'b1;
			cur       = tok_q[1];
		end else begin
			sel_oh[2] = vld_q[2];
		end
	end

	assign tok_valid    = (vld_q != '0);
	assign xfer         = tok_valid && tok_ready;
	assign token_kind   = cur.kind;
	assign token_start  = cur.start;
	assign token_length = cur.len;
	assign final_token  = (cur.kind == KIND_END);

	// refill once the held bundle is empty or its last token leaves this cycle
	assign rest    = vld_q & ~sel_oh;
	assign load_ok = (rest == '0) && (!tok_valid || tok_ready);
	assign q_pop   = load_ok && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (q_pop) begin
			vld_q <= q_rdata.vld;
		end else if (xfer) begin
			vld_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tok_q <= q_rdata.tok;
		end
	end

endmodule
`default_nettype wire

>>> design/expression_byte_tokenizer.sv
`default_nettype none
// expression byte tokenizer
// src channel: one source byte per transfer (source_byte, byte_present,
// end_of_source); an item with byte_present low and end_of_source high
// only closes the source text.
// tok channel: one token per transfer (token_kind, token_start,
// token_length, final_token); final_token marks the end token.
// the front classifies each accepted byte against the open run and writes
// up to three tokens as one entry into a four-entry queue; the back pulls
// entries and hands out their tokens one per cycle while tok_ready is high.
// src_ready is high whenever the queue has room, so one byte per cycle is
// taken; bytes that only extend a run use no queue entry.
// a token passes a queue entry and then the back register before it is
// offered. when tok_ready stays low the back keeps its entry, the queue
// fills and src_ready drops after four pending entries.
// reset empties the queue and the back register and restarts at offset 0;
// the end token also returns the front to offset 0 for the next source.
module expression_byte_tokenizer #(
	parameter int MAX_SOURCE_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_ready,
	input  wire logic [7:0]  source_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_source,
	output logic             tok_valid,
	input  wire logic        tok_ready,
	output logic [3:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [16:0]      token_length,
	output logic             final_token
);
	import ebt_pkg::*;

	logic    q_push, q_pop, q_full, q_empty;
	bundle_t q_wdata, q_rdata;

	ebt_front #(
		.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.source_byte  (source_byte),
		.byte_present (byte_present),
		.end_of_source(end_of_source),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	ebt_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	ebt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_rdata     (q_rdata),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.tok_valid   (tok_valid),
		.tok_ready   (tok_ready),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.final_token (final_token)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_len_final: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (final_token == (token_length == '0)))
		else $error("zero length on a token other than end");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready && end_of_source) |=> src_ready || q_full)
		else $error("front blocked without a full queue");

endmodule
`default_nettype wire
